### rtl/shb_pkg.sv
// Package for the SHA-256 byte stream hasher: initial hash values, round
// constants and the round functions. No dependencies.
`default_nettype none
package shb_pkg;

  localparam int unsigned NumWords = 8;
  localparam int unsigned WinWords = 16;
  localparam int unsigned NumRounds = 64;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  localparam logic [31:0] InitHash [NumWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage
`default_nettype wire

### rtl/shb_stream_if.sv
// Valid/ready channels of the hasher: byte requests in, digest words out.
// Depends on nothing.
`default_nettype none
interface shb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
endinterface

interface shb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface
`default_nettype wire

### rtl/sha256_byte_stream_hasher_unit.sv
// Byte request without block end: taken while idle. Byte that fills a block: load,
// 64 rounds on the one shared round unit, chaining add. Closing request: one padding
// byte per cycle up to byte 63, one or two compressions, then 8 digest words, one per
// cycle while the output is ready. No request is taken during padding, rounds or output.
// Reset: idle, chaining words at the initial hash values, fill and length at zero.
// Uses shb_pkg and the interfaces in shb_stream_if.sv.
`default_nettype none
module sha256_byte_stream_hasher_unit
  import shb_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  shb_in_if.sink      in_i,
  shb_out_if.source   out_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFinal = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  localparam logic [1:0] AftIdle = 2'd0;
  localparam logic [1:0] AftPad  = 2'd1;
  localparam logic [1:0] AftOut  = 2'd2;

  logic [2:0]  state_q, state_d;
  logic [1:0]  after_q, after_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] count_q, count_d;
  logic [5:0]  pos_q, pos_d;
  logic        mark_q, mark_d;
  logic        lenblk_q, lenblk_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] h_q [NumWords];
  logic [31:0] h_d [NumWords];
  logic [31:0] v_q [NumWords];
  logic [31:0] v_d [NumWords];
  logic [31:0] w_q [WinWords];
  logic [31:0] w_d [WinWords];

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic        start_cmp;
  logic [6:0]  new_fill;
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;
  logic [31:0] t1, t2, w_new;
  logic        in_acc, out_acc;

  assign in_i.ready = (state_q == StIdle);
  assign in_acc = in_i.valid && in_i.ready;
  assign out_o.valid = (state_q == StOut);
  assign out_acc = out_o.valid && out_o.ready;
  assign out_o.digest_word = h_q[idx_q];
  assign out_o.word_index = idx_q;
  assign out_o.last_word = (idx_q == 3'(NumWords - 1));

  assign new_fill = {1'b0, fill_q} + {6'd0, in_i.has_byte};
  assign bit_len = {count_q, 3'b000};

  always_comb begin
    if (!mark_q) begin
      pad_byte = PadMark;
    end else if (lenblk_q && (pos_q >= LenStart)) begin
      pad_byte = bit_len[{~pos_q[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // One round of the shared unit, plus the schedule word sixteen ahead.
  assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
            + RoundK[rnd_q] + w_q[0];
  assign t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);
  assign w_new = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);

  always_comb begin
    state_d = state_q;
    after_d = after_q;
    fill_d = fill_q;
    count_d = count_q;
    pos_d = pos_q;
    mark_d = mark_q;
    lenblk_d = lenblk_q;
    rnd_d = rnd_q;
    idx_d = idx_q;
    h_d = h_q;
    v_d = v_q;
    w_d = w_q;
    wr_en = 1'b0;
    wr_pos = fill_q;
    wr_byte = in_i.data_byte;
    start_cmp = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (in_i.has_byte) begin
            wr_en = 1'b1;
            count_d = count_q + 61'd1;
          end
          if (new_fill[6]) begin
            start_cmp = 1'b1;
            fill_d = '0;
            after_d = in_i.last ? AftPad : AftIdle;
            pos_d = '0;
            mark_d = 1'b0;
            lenblk_d = 1'b1;
          end else begin
            fill_d = new_fill[5:0];
            if (in_i.last) begin
              state_d = StPad;
              pos_d = new_fill[5:0];
              mark_d = 1'b0;
              lenblk_d = (new_fill[5:0] < LenStart);
            end
          end
        end
      end
      StPad: begin
        wr_en = 1'b1;
        wr_pos = pos_q;
        wr_byte = pad_byte;
        mark_d = 1'b1;
        if (pos_q == 6'd63) begin
          start_cmp = 1'b1;
          after_d = lenblk_q ? AftOut : AftPad;
          pos_d = '0;
          lenblk_d = 1'b1;
        end else begin
          pos_d = pos_q + 6'd1;
        end
      end
      StRound: begin
        for (int i = 0; i < WinWords - 1; i++) begin
          w_d[i] = w_q[i + 1];
        end
        w_d[WinWords - 1] = w_new;
        v_d[7] = v_q[6];
        v_d[6] = v_q[5];
        v_d[5] = v_q[4];
        v_d[4] = v_q[3] + t1;
        v_d[3] = v_q[2];
        v_d[2] = v_q[1];
        v_d[1] = v_q[0];
        v_d[0] = t1 + t2;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'(NumRounds - 1)) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        for (int i = 0; i < NumWords; i++) begin
          h_d[i] = h_q[i] + v_q[i];
        end
        idx_d = '0;
        case (after_q)
          AftPad:  state_d = StPad;
          AftOut:  state_d = StOut;
          default: state_d = StIdle;
        endcase
      end
      StOut: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (out_o.last_word) begin
            h_d = InitHash;
            count_d = '0;
            fill_d = '0;
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (wr_en) begin
      w_d[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] = wr_byte;
    end
    // Load the working variables and run the rounds on the finished block.
    if (start_cmp) begin
      v_d = h_q;
      rnd_d = '0;
      state_d = StRound;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      after_q <= AftIdle;
      fill_q <= '0;
      count_q <= '0;
      pos_q <= '0;
      mark_q <= 1'b0;
      lenblk_q <= 1'b0;
      rnd_q <= '0;
      idx_q <= '0;
      h_q <= InitHash;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      fill_q <= fill_d;
      count_q <= count_d;
      pos_q <= pos_d;
      mark_q <= mark_d;
      lenblk_q <= lenblk_d;
      rnd_q <= rnd_d;
      idx_q <= idx_d;
      h_q <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    w_q <= w_d;
  end

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("request taken while digest words are pending");

  a_final_after_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinal) |-> ($past(state_q) == StRound && $past(rnd_q) == 6'd63))
    else $error("chaining add without a full set of rounds");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_word) |=> (in_i.ready && fill_q == '0 && count_q == '0))
    else $error("message state not cleared after the digest");

  a_pad_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPad && lenblk_q && pos_q >= LenStart) |-> mark_q)
    else $error("length bytes overlap the padding mark");

endmodule
`default_nettype wire

### tb/sha256_byte_stream_hasher_unit_checker.sv
// Checker for the SHA-256 byte stream hasher: watches both channels, keeps its own
// digest state and compares every digest word against it.
// Depends on the channel interfaces in shb_stream_if.sv.
module sha256_byte_stream_hasher_unit_checker (
  input  logic clk_i,
  input  logic rst_ni,
  shb_in_if    in_mon_i,
  shb_out_if   out_mon_i,
  output int   pending_o,
  output int   mismatch_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0]  hash_words [8];
  logic [7:0]   block_buf [64];
  int           block_fill;
  logic [60:0]  msg_len;
  digest_word_t digest_queue [$];
  digest_word_t seen_word;
  digest_word_t want_word;
  int           mismatches;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] x, y, e, a, t1, t2;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      x = sched[i-15];
      y = sched[i-2];
      sched[i] = sched[i-16] + (rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3)) + sched[i-7]
               + (rotr32(y, 17) ^ rotr32(y, 19) ^ (y >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_words[i];
    for (int i = 0; i < 64; i++) begin
      e = v[4];
      a = v[0];
      t1 = v[7] + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25))
         + ((e & v[5]) ^ (~e & v[6])) + RoundConst[i] + sched[i];
      t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22))
         + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = e;
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = a;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_words[i] += v[i];
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) hash_words[i] = StartHash[i];
    block_fill = 0;
    msg_len = '0;
  endfunction

  // Absorb one request; a closing request pads, compresses and queues the digest.
  function automatic void absorb_request(input logic [7:0] data, input logic has_data,
                                         input logic close);
    logic [63:0] bit_len;
    digest_word_t w;
    if (has_data) begin
      block_buf[block_fill] = data;
      block_fill++;
      msg_len++;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (close) begin
      bit_len = {msg_len, 3'b000};
      block_buf[block_fill] = 8'h80;
      block_fill++;
      // no room left for the length: flush this block first
      if (block_fill > 56) begin
        for (int i = block_fill; i < 64; i++) block_buf[i] = 8'h00;
        compress_block();
        block_fill = 0;
      end
      for (int i = block_fill; i < 56; i++) block_buf[i] = 8'h00;
      for (int i = 0; i < 8; i++) block_buf[63-i] = bit_len[8*i +: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        w.word = hash_words[i];
        w.index = 3'(i);
        w.last = (i == 7);
        digest_queue.push_back(w);
      end
      restart_message();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_message();
      digest_queue.delete();
      mismatches = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        absorb_request(in_mon_i.data_byte, in_mon_i.has_byte, in_mon_i.last);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        seen_word.word = out_mon_i.digest_word;
        seen_word.index = out_mon_i.word_index;
        seen_word.last = out_mon_i.last_word;
        if (digest_queue.size() == 0) begin
          $error("unexpected digest word %08h index %0d", seen_word.word, seen_word.index);
          mismatches++;
        end else begin
          want_word = digest_queue.pop_front();
          if (seen_word.word !== want_word.word) begin
            $error("digest_word: expected %08h, got %08h", want_word.word, seen_word.word);
            mismatches++;
          end
          if (seen_word.index !== want_word.index) begin
            $error("word_index: expected %0d, got %0d", want_word.index, seen_word.index);
            mismatches++;
          end
          if (seen_word.last !== want_word.last) begin
            $error("last_word: expected %0b, got %0b", want_word.last, seen_word.last);
            mismatches++;
          end
        end
      end
    end
    pending_o = digest_queue.size();
    mismatch_count_o = mismatches;
  end

endmodule

### tb/sha256_byte_stream_hasher_unit_tb.sv
// Top of the SHA-256 byte stream hasher testbench: clock, reset, request stimulus,
// output backpressure and verdict. Depends on shb_stream_if.sv, the hasher and its checker.
module sha256_byte_stream_hasher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems = 250;
  localparam int DrainCycles = 300;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   mismatch_count;
  int   item_count;
  int   gap_pct;
  int   stall_pct;

  shb_in_if  in_ch ();
  shb_out_if out_ch ();

  sha256_byte_stream_hasher_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  sha256_byte_stream_hasher_unit_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon_i        (in_ch),
    .out_mon_i       (out_ch),
    .pending_o       (pending),
    .mismatch_count_o(mismatch_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Move the idle pattern along with the number of requests that count.
  function automatic void set_pressure();
    if (item_count < RandomItems / 3) begin
      gap_pct = 19;
      stall_pct = 67;
    end else if (item_count < 2 * RandomItems / 3) begin
      gap_pct = 67;
      stall_pct = 19;
    end else begin
      gap_pct = 0;
      stall_pct = 0;
    end
  endfunction

  task automatic send_request(input logic [7:0] data, input logic has_data, input logic close);
    @(negedge clk_i);
    set_pressure();
    while ($urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.has_byte <= has_data;
    in_ch.last <= close;
    do @(posedge clk_i); while (!(in_ch.valid && in_ch.ready));
    if (has_data || close) item_count++;
  endtask

  // One message of random bytes, closed on its final byte or by an empty request.
  task automatic hash_message(input int len);
    logic close_on_byte;
    close_on_byte = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) send_request(8'($urandom()), 1'b0, 1'b0);
      send_request(8'($urandom()), 1'b1, close_on_byte && (i == len - 1));
    end
    if (len == 0 || !close_on_byte) send_request(8'($urandom()), 1'b0, 1'b1);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    int boundary_len [8];
    int len;
    boundary_len = '{55, 56, 57, 63, 64, 65, 119, 120};
    item_count = 0;
    gap_pct = 19;
    stall_pct = 67;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.has_byte = 1'b0;
    in_ch.last = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty message, then an ignored request
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h5a, 1'b0, 1'b0);
    // "abc", closed on its final byte
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // extreme bytes, closed by an empty request with a stray ignored request between
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hff, 1'b0, 1'b1);
    // single byte on the closing request
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);

    while (item_count < RandomItems) begin
      if ($urandom_range(0, 5) == 0) len = boundary_len[$urandom_range(0, 7)];
      else len = $urandom_range(0, 12);
      hash_message(len);
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
rtl/shb_pkg.sv
rtl/shb_stream_if.sv
rtl/sha256_byte_stream_hasher_unit.sv
tb/sha256_byte_stream_hasher_unit_checker.sv
tb/sha256_byte_stream_hasher_unit_tb.sv
